FILE: rtl/symbol_frequency_histogram_unit_assert.svh
`ifndef SYMBOL_FREQUENCY_HISTOGRAM_UNIT_ASSERT_SVH
`define SYMBOL_FREQUENCY_HISTOGRAM_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SFH_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("histogram unit: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SFH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("histogram unit: next-cycle check failed");

`endif

FILE: rtl/sfh_pkg.sv
package sfh_pkg;

  // Fixed field widths of the item, the result and the configuration port.
  localparam int SYM_BITS        = 16;
  localparam int LEN_BITS        = 17;
  localparam int READ_COUNT_BITS = 32;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 17;

  // Function codes of an input item.
  localparam logic [1:0] FUNC_DATA  = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ELEMENT_BYTES = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TABLE_LENGTH  = 2'd1;

  // Reset value of the table length register.
  localparam logic [LEN_BITS-1:0] TABLE_LENGTH_RESET = 17'd256;

  // One input item.
  typedef struct packed {
    logic [1:0]          func;
    logic [7:0]          data_byte;
    logic                end_of_buffer;
    logic [SYM_BITS-1:0] read_index;
  } sfh_in_t;

  // One result item.
  typedef struct packed {
    logic [READ_COUNT_BITS-1:0] read_count;
    logic [SYM_BITS-1:0]        min_symbol;
    logic                       min_valid;
    logic                       symbol_counted;
    logic                       symbol_dropped;
  } sfh_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic finish;
    logic clr_run;
  } sfh_cmd_t;

endpackage

FILE: rtl/sfh_ctrl.sv
`include "symbol_frequency_histogram_unit_assert.svh"

module sfh_ctrl
  import sfh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] func,
  input  logic       clr_last,
  output logic       busy,
  output logic       done,
  output sfh_cmd_t   cmd
);

  typedef enum logic [1:0] {
    S_WIPE,
    S_IDLE,
    S_CLEAR,
    S_FINISH
  } state_t;

  state_t state;

  // Busy and the commands follow from the state; accept also needs start.
  always_comb begin
    busy        = (state != S_IDLE);
    cmd.accept  = start && (state == S_IDLE);
    cmd.finish  = (state == S_FINISH);
    cmd.clr_run = (state == S_WIPE) || (state == S_CLEAR);
  end

  // State and the registered result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_WIPE;
      done  <= 1'b0;
    end else begin
      done <= (state == S_FINISH);
      case (state)
        S_WIPE: begin
          if (clr_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            if (func == FUNC_CLEAR) state <= S_CLEAR;
            else state <= S_FINISH;
          end
        end
        S_CLEAR: begin
          if (clr_last) state <= S_FINISH;
        end
        S_FINISH: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SFH_ASSERT_NEXT(a_accept_busy, clk, rst, cmd.accept, busy)
  `SFH_ASSERT_NEXT(a_finish_done, clk, rst, state == S_FINISH, done && !busy)
  `SFH_ASSERT_NOW(a_done_idle, clk, rst, done, !busy)

endmodule

FILE: rtl/sfh_datapath.sv
`include "symbol_frequency_histogram_unit_assert.svh"

module sfh_datapath
  import sfh_pkg::*;
#(
  parameter int TABLE_DEPTH       = 65536,
  parameter int MAX_ELEMENT_BYTES = 2,
  parameter int COUNT_BITS        = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  sfh_in_t                   item,
  input  sfh_cmd_t                  cmd,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output logic                      clr_last,
  output sfh_out_t                  result
);

  localparam int ADDR_BITS = $clog2(TABLE_DEPTH);
  localparam logic [LEN_BITS-1:0]  DEPTH_LEN = LEN_BITS'(TABLE_DEPTH);
  localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(TABLE_DEPTH - 1);

  // Counter memory with one write port and one registered read port.
  logic [COUNT_BITS-1:0] count_mem [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] mem_rdata;
  logic                  mem_we;
  logic [ADDR_BITS-1:0]  mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [ADDR_BITS-1:0]  mem_raddr;

  // Configuration and assembly state.
  logic                two_byte;
  logic [LEN_BITS-1:0] table_length;
  logic [7:0]          partial_symbol;
  logic                byte_position;
  logic [SYM_BITS-1:0] smallest_seen;
  logic                smallest_valid;
  logic [ADDR_BITS-1:0] clr_addr;

  // Item held between accept and finish.
  logic                 pend_count;
  logic                 pend_drop;
  logic                 pend_rd;
  logic [SYM_BITS-1:0]  pend_sym;
  logic [ADDR_BITS-1:0] pend_addr;

  // Symbol assembly from the incoming byte.
  logic [SYM_BITS-1:0] sym;
  logic                sym_done;
  logic                sym_in_range;
  logic                ridx_in_range;
  logic                is_data;

  always_comb begin
    is_data  = (item.func == FUNC_DATA);
    sym      = {8'd0, item.data_byte};
    sym_done = 1'b0;
    if (byte_position) begin
      sym      = {item.data_byte, partial_symbol};
      sym_done = 1'b1;
    end else if (!two_byte) begin
      sym_done = 1'b1;
    end
    sym_in_range  = ({1'b0, sym} < table_length) && ({1'b0, sym} < DEPTH_LEN);
    ridx_in_range = ({1'b0, item.read_index} < table_length) &&
                    ({1'b0, item.read_index} < DEPTH_LEN);
    mem_raddr = is_data ? sym[ADDR_BITS-1:0] : item.read_index[ADDR_BITS-1:0];
  end

  // Minimum after this item's update and the saturated counter value.
  logic                  min_upd;
  logic [SYM_BITS-1:0]   min_next;
  logic                  min_valid_next;
  logic [COUNT_BITS-1:0] count_inc;

  always_comb begin
    min_upd        = pend_count && (!smallest_valid || (pend_sym < smallest_seen));
    min_next       = min_upd ? pend_sym : smallest_seen;
    min_valid_next = smallest_valid || pend_count;
    count_inc      = (&mem_rdata) ? mem_rdata : mem_rdata + COUNT_BITS'(1);
  end

  // Write port: clearing sweep or the counted symbol's increment.
  always_comb begin
    clr_last  = (clr_addr == LAST_ADDR);
    mem_we    = cmd.clr_run || (cmd.finish && pend_count);
    mem_waddr = cmd.clr_run ? clr_addr : pend_addr;
    mem_wdata = cmd.clr_run ? '0 : count_inc;
  end

  always_ff @(posedge clk) begin
    if (mem_we) count_mem[mem_waddr] <= mem_wdata;
    if (cmd.accept) mem_rdata <= count_mem[mem_raddr];
  end

  // Control state of the datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      two_byte       <= 1'b0;
      table_length   <= TABLE_LENGTH_RESET;
      partial_symbol <= 8'd0;
      byte_position  <= 1'b0;
      smallest_seen  <= '0;
      smallest_valid <= 1'b0;
      clr_addr       <= '0;
    end else begin
      if (cfg_we && (cfg_index == CFG_ELEMENT_BYTES)) begin
        two_byte       <= (cfg_data[1:0] >= 2'd2) && (MAX_ELEMENT_BYTES >= 2);
        partial_symbol <= 8'd0;
        byte_position  <= 1'b0;
      end
      if (cfg_we && (cfg_index == CFG_TABLE_LENGTH)) begin
        table_length <= cfg_data;
      end
      if (cmd.clr_run) begin
        clr_addr <= clr_last ? '0 : clr_addr + ADDR_BITS'(1);
      end
      // A completed symbol or a buffer end restarts assembly at the low byte.
      if (cmd.accept && is_data) begin
        if (byte_position || item.end_of_buffer) begin
          byte_position  <= 1'b0;
          partial_symbol <= 8'd0;
        end else if (two_byte) begin
          byte_position  <= 1'b1;
          partial_symbol <= item.data_byte;
        end
      end
      if (cmd.accept && (item.func == FUNC_CLEAR)) begin
        smallest_seen  <= '0;
        smallest_valid <= 1'b0;
      end
      if (cmd.finish) begin
        smallest_seen  <= min_next;
        smallest_valid <= min_valid_next;
      end
    end
  end

  // Item capture at accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_count <= 1'b0;
      pend_drop  <= 1'b0;
      pend_rd    <= 1'b0;
    end else if (cmd.accept) begin
      pend_count <= is_data && sym_done && sym_in_range;
      pend_drop  <= is_data && sym_done && !sym_in_range;
      pend_rd    <= (item.func == FUNC_READ) && ridx_in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_sym  <= sym;
      pend_addr <= sym[ADDR_BITS-1:0];
    end
  end

  // Result register, loaded when the item finishes.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.read_count     <= pend_rd ? READ_COUNT_BITS'(mem_rdata) : '0;
      result.min_symbol     <= min_valid_next ? min_next : '0;
      result.min_valid      <= min_valid_next;
      result.symbol_counted <= pend_count;
      result.symbol_dropped <= pend_drop;
    end
  end

  `SFH_ASSERT_NOW(a_count_drop_excl, clk, rst, cmd.finish, !(pend_count && pend_drop))
  `SFH_ASSERT_NEXT(a_count_sets_min, clk, rst, cmd.finish && pend_count, smallest_valid)
  `SFH_ASSERT_NEXT(a_clear_forgets_min, clk, rst, cmd.accept && (item.func == FUNC_CLEAR),
                   !smallest_valid)

endmodule

FILE: rtl/symbol_frequency_histogram_unit.sv
// Byte-stream symbol histogram. An item is accepted at a rising edge with start high
// and busy low. Data bytes, counter reads and the unused function code read the
// counter memory through its registered read port when accepted, then pass through
// the finish state, where a counted byte writes back the saturated increment through
// its single write port. The result is shown for exactly one cycle with done high,
// in the cycle after the item finishes, and must be captured then because it cannot
// be held off; busy is already low in that cycle, so a new item may be accepted
// alongside it. A clear command sweeps the counter memory one entry per cycle and
// then finishes like any other item before the next item can be accepted. After
// reset the same sweep runs with busy high and produces no result. Configuration
// writes are always ready and are to be made only while the block is idle.
module symbol_frequency_histogram_unit
  import sfh_pkg::*;
#(
  parameter int TABLE_DEPTH       = 65536,
  parameter int MAX_ELEMENT_BYTES = 2,
  parameter int COUNT_BITS        = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  sfh_in_t                   item,
  output logic                      done,
  output sfh_out_t                  result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  sfh_cmd_t cmd;
  logic     clr_last;

  // The configuration registers take a write in any cycle.
  assign cfg_ready = 1'b1;

  sfh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .func     (item.func),
    .clr_last (clr_last),
    .busy     (busy),
    .done     (done),
    .cmd      (cmd)
  );

  sfh_datapath #(
    .TABLE_DEPTH       (TABLE_DEPTH),
    .MAX_ELEMENT_BYTES (MAX_ELEMENT_BYTES),
    .COUNT_BITS        (COUNT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (cmd),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .clr_last  (clr_last),
    .result    (result)
  );

endmodule
